// ===== rtl/core/gift128_block_cipher_core_defines.svh =====
// assertion macros for the gift-128 cipher core and its checker
`ifndef GIFT128_BLOCK_CIPHER_CORE_DEFINES_SVH
`define GIFT128_BLOCK_CIPHER_CORE_DEFINES_SVH

// checked only while out of reset
`define GIFT128_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("gift128 check failed");

// checked at every edge, reset included
`define GIFT128_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("gift128 reset check failed");

`endif

// ===== rtl/core/gift128_pkg.sv =====
// shared types, tables and round functions of the gift-128 cipher core
`default_nettype none

package gift128_pkg;

  localparam int unsigned GIFT_ROUNDS = 40;
  localparam int unsigned RC_COUNT    = 48;
  localparam int unsigned BLOCK_W     = 128;
  localparam int unsigned HALF_W      = 64;

  // operation carried with each beat
  typedef enum logic {
    OP_ENC = 1'b0,
    OP_DEC = 1'b1
  } op_e;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_KEY_LOW  = 1'b0,
    CFG_KEY_HIGH = 1'b1
  } cfg_e;

  // control that travels beside the block in every stage
  typedef struct packed {
    logic valid;
    op_e  op;
  } ctl_t;

  // six-bit round constants
  localparam logic [5:0] RCON [RC_COUNT] = '{
    6'h01, 6'h03, 6'h07, 6'h0F, 6'h1F, 6'h3E, 6'h3D, 6'h3B,
    6'h37, 6'h2F, 6'h1E, 6'h3C, 6'h39, 6'h33, 6'h27, 6'h0E,
    6'h1D, 6'h3A, 6'h35, 6'h2B, 6'h16, 6'h2C, 6'h18, 6'h30,
    6'h21, 6'h02, 6'h05, 6'h0B, 6'h17, 6'h2E, 6'h1C, 6'h38,
    6'h31, 6'h23, 6'h06, 6'h0D, 6'h1B, 6'h36, 6'h2D, 6'h1A,
    6'h34, 6'h29, 6'h12, 6'h24, 6'h08, 6'h11, 6'h22, 6'h04
  };

  // forward s-box
  function automatic logic [3:0] sbox_fwd(logic [3:0] x);
    logic [3:0] y;
    unique case (x)
      4'h0: y = 4'h1;
      4'h1: y = 4'ha;
      4'h2: y = 4'h4;
      4'h3: y = 4'hc;
      4'h4: y = 4'h6;
      4'h5: y = 4'hf;
      4'h6: y = 4'h3;
      4'h7: y = 4'h9;
      4'h8: y = 4'h2;
      4'h9: y = 4'hd;
      4'ha: y = 4'hb;
      4'hb: y = 4'h7;
      4'hc: y = 4'h5;
      4'hd: y = 4'h0;
      4'he: y = 4'h8;
      4'hf: y = 4'he;
      default: y = 4'h0;
    endcase
    return y;
  endfunction

  // inverse s-box
  function automatic logic [3:0] sbox_bwd(logic [3:0] x);
    logic [3:0] y;
    unique case (x)
      4'h0: y = 4'hd;
      4'h1: y = 4'h0;
      4'h2: y = 4'h8;
      4'h3: y = 4'h6;
      4'h4: y = 4'h2;
      4'h5: y = 4'hc;
      4'h6: y = 4'h4;
      4'h7: y = 4'hb;
      4'h8: y = 4'he;
      4'h9: y = 4'h7;
      4'ha: y = 4'h1;
      4'hb: y = 4'ha;
      4'hc: y = 4'h3;
      4'hd: y = 4'h9;
      4'he: y = 4'hf;
      4'hf: y = 4'h5;
      default: y = 4'h0;
    endcase
    return y;
  endfunction

  // s-box layer over all 32 cells
  function automatic logic [BLOCK_W-1:0] sub_layer(logic [BLOCK_W-1:0] s, logic inv);
    logic [BLOCK_W-1:0] o;
    o = '0;
    for (int n = 0; n < BLOCK_W / 4; n++) begin
      o[4*n +: 4] = inv ? sbox_bwd(s[4*n +: 4]) : sbox_fwd(s[4*n +: 4]);
    end
    return o;
  endfunction

  // destination of bit i under the bit permutation
  function automatic logic [6:0] perm_dest(int unsigned i);
    int unsigned p;
    p = 4 * (i >> 4) + 32 * ((3 * ((i & 15) >> 2) + (i & 3)) & 3) + (i & 3);
    return p[6:0];
  endfunction

  // forward bit permutation
  function automatic logic [BLOCK_W-1:0] perm_fwd(logic [BLOCK_W-1:0] s);
    logic [BLOCK_W-1:0] o;
    o = '0;
    for (int unsigned i = 0; i < BLOCK_W; i++) begin
      o[perm_dest(i)] = s[i];
    end
    return o;
  endfunction

  // inverse bit permutation
  function automatic logic [BLOCK_W-1:0] perm_inv(logic [BLOCK_W-1:0] s);
    logic [BLOCK_W-1:0] o;
    o = '0;
    for (int unsigned i = 0; i < BLOCK_W; i++) begin
      o[i] = s[perm_dest(i)];
    end
    return o;
  endfunction

  // round key from key state and round constant
  function automatic logic [BLOCK_W-1:0] make_round_key(logic [BLOCK_W-1:0] ks,
                                                        logic [5:0]         rc);
    logic [BLOCK_W-1:0] rk;
    rk = '0;
    for (int i = 0; i < 32; i++) begin
      rk[4*i+1] = ks[i];
      rk[4*i+2] = ks[HALF_W+i];
    end
    for (int i = 0; i < 6; i++) begin
      rk[4*i+3] = rc[i];
    end
    rk[BLOCK_W-1] = 1'b1;
    return rk;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gift128_key_sched.sv =====
// key schedule: round keys of every round from the 128-bit key
`default_nettype none

module gift128_key_sched #(
  parameter int unsigned ROUNDS = gift128_pkg::GIFT_ROUNDS
) (
  input  logic [gift128_pkg::BLOCK_W-1:0]             key_i,
  output logic [ROUNDS-1:0][gift128_pkg::BLOCK_W-1:0] rk_o
);
  import gift128_pkg::*;

  // key state at the start of each round
  logic [ROUNDS-1:0][BLOCK_W-1:0] ks;

  assign ks[0] = key_i;

  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    // round key with its constant
    assign rk_o[r] = make_round_key(ks[r], RCON[r % RC_COUNT]);

    // word rotation plus the two 16-bit rotates
    if (r < ROUNDS - 1) begin : g_next
      logic [15:0] w0;
      logic [15:0] w1;
      assign w0 = {ks[r][11:0], ks[r][15:12]};
      assign w1 = {ks[r][17:16], ks[r][31:18]};
      assign ks[r+1] = {w1, w0, ks[r][127:96], ks[r][95:64], ks[r][63:32]};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/gift128_round_stage.sv =====
// one pipelined round: encrypt or decrypt round chosen per beat
`default_nettype none

module gift128_round_stage (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  gift128_pkg::ctl_t               ctl_i,
  input  logic [gift128_pkg::BLOCK_W-1:0] data_i,
  input  logic [gift128_pkg::BLOCK_W-1:0] enc_rk_i,
  input  logic [gift128_pkg::BLOCK_W-1:0] dec_rk_i,
  output gift128_pkg::ctl_t               ctl_o,
  output logic [gift128_pkg::BLOCK_W-1:0] data_o
);
  import gift128_pkg::*;

  ctl_t               ctl_q;
  logic [BLOCK_W-1:0] data_d;
  logic [BLOCK_W-1:0] data_q;
  logic [BLOCK_W-1:0] enc_res;
  logic [BLOCK_W-1:0] dec_res;

  // encrypt: s-box, permutation, key add
  assign enc_res = perm_fwd(sub_layer(data_i, 1'b0)) ^ enc_rk_i;

  // decrypt: key add, inverse permutation, inverse s-box
  assign dec_res = sub_layer(perm_inv(data_i ^ dec_rk_i), 1'b1);

  assign data_d = (ctl_i.op == OP_DEC) ? dec_res : enc_res;

  // control register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '{valid: 1'b0, op: OP_ENC};
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  // data register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign ctl_o  = ctl_q;
  assign data_o = data_q;

endmodule

`default_nettype wire

// ===== rtl/core/gift128_block_cipher_core.sv =====
// gift-128 cipher core: one register stage per round, skid buffer at the input
// an accepted input beat reaches the output through the round registers in order
// throughput: one block per cycle while the output is not stalled, set by the fully unrolled round pipeline
// a stalled output freezes the pipeline; one more input beat parks in the skid buffer
// reset clears all valid bits and both key registers to zero
`default_nettype none

module gift128_block_cipher_core #(
  parameter int unsigned ROUNDS = gift128_pkg::GIFT_ROUNDS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [63:0] block_low_i,
  input  logic [63:0] block_high_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] result_low_o,
  output logic [63:0] result_high_o
);
  import gift128_pkg::*;

  logic [HALF_W-1:0]              key_low_q;
  logic [HALF_W-1:0]              key_high_q;
  logic [ROUNDS-1:0][BLOCK_W-1:0] rk;

  logic               skid_valid_d;
  logic               skid_valid_q;
  op_e                skid_op_q;
  logic [BLOCK_W-1:0] skid_data_q;

  logic               in_accept;
  logic               adv;
  ctl_t               front_ctl;
  logic [BLOCK_W-1:0] front_data;

  ctl_t               ctl_chain  [ROUNDS+1];
  logic [BLOCK_W-1:0] data_chain [ROUNDS+1];

  // key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KEY_LOW:  key_low_q  <= cfg_wdata_i;
        CFG_KEY_HIGH: key_high_q <= cfg_wdata_i;
      endcase
    end
  end

  gift128_key_sched #(
    .ROUNDS(ROUNDS)
  ) u_key_sched (
    .key_i({key_high_q, key_low_q}),
    .rk_o (rk)
  );

  // pipeline moves unless the output beat is held
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i && !skid_valid_q;

  // skid buffer catches a beat while the pipeline is frozen
  always_comb begin
    skid_valid_d = skid_valid_q;
    if (adv) begin
      skid_valid_d = 1'b0;
    end else if (in_accept) begin
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q <= 1'b0;
    end else begin
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!adv && in_accept) begin
      skid_op_q   <= op_e'(opcode_i);
      skid_data_q <= {block_high_i, block_low_i};
    end
  end

  // pipeline entry: parked beat first, else the port
  always_comb begin
    if (skid_valid_q) begin
      front_ctl  = '{valid: 1'b1, op: skid_op_q};
      front_data = skid_data_q;
    end else begin
      front_ctl  = '{valid: in_accept, op: op_e'(opcode_i)};
      front_data = {block_high_i, block_low_i};
    end
  end

  assign ctl_chain[0]  = front_ctl;
  assign data_chain[0] = front_data;

  // one stage per round; decryption walks the keys backward
  for (genvar k = 0; k < ROUNDS; k++) begin : g_stage
    gift128_round_stage u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .ctl_i   (ctl_chain[k]),
      .data_i  (data_chain[k]),
      .enc_rk_i(rk[k]),
      .dec_rk_i(rk[ROUNDS-1-k]),
      .ctl_o   (ctl_chain[k+1]),
      .data_o  (data_chain[k+1])
    );
  end

  // last stage is the output register
  assign out_valid_o   = ctl_chain[ROUNDS].valid;
  assign result_low_o  = data_chain[ROUNDS][HALF_W-1:0];
  assign result_high_o = data_chain[ROUNDS][BLOCK_W-1:HALF_W];

endmodule

`default_nettype wire

// ===== rtl/core/gift128_checker.sv =====
// port-level checks of the gift-128 cipher core, bound to the top level
`default_nettype none

`include "gift128_block_cipher_core_defines.svh"

module gift128_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] result_low_o,
  input logic [63:0] result_high_o
);

  // reset empties the pipeline and the skid buffer
  `GIFT128_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !out_valid_o && !in_stall_o)

  // a held output beat stays with its payload
  `GIFT128_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(result_low_o) && $stable(result_high_o))

  // input side only pushes back while an output beat waits
  `GIFT128_ASSERT(a_stall_needs_out, in_stall_o |-> out_valid_o)

  // skid fills only on a cycle with the output held
  `GIFT128_ASSERT(a_stall_rise, $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))

endmodule

bind gift128_block_cipher_core gift128_checker u_checker (.*);

`default_nettype wire
